// File: sv/md5_pkg.sv
// md5_pkg: shared types, sequencer states and round tables for the md5 stream hash
// no dependencies; compiled first

package md5_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] quad_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} rnd_ctrl_t;

	typedef struct packed {
		logic active;
		logic mark;
		logic len;
	} pad_t;

	localparam word_t CHAIN_INIT0 = 32'h67452301;
	localparam word_t CHAIN_INIT1 = 32'hefcdab89;
	localparam word_t CHAIN_INIT2 = 32'h98badcfe;
	localparam word_t CHAIN_INIT3 = 32'h10325476;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [3:0] LEN_WORD_LO = 4'd14;
	localparam logic [3:0] LEN_WORD_HI = 4'd15;
	localparam logic [5:0] LAST_BYTE = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [5:0] LEN_FIT_MAX = 6'd55;
	localparam logic [1:0] LAST_WORD = 2'd3;

	function automatic word_t round_const(input logic [5:0] r);
		word_t k;
		case (r)
			6'd0: k = 32'hd76aa478;
			6'd1: k = 32'he8c7b756;
			6'd2: k = 32'h242070db;
			6'd3: k = 32'hc1bdceee;
			6'd4: k = 32'hf57c0faf;
			6'd5: k = 32'h4787c62a;
			6'd6: k = 32'ha8304613;
			6'd7: k = 32'hfd469501;
			6'd8: k = 32'h698098d8;
			6'd9: k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] r);
		logic [4:0] s;
		case ({r[5:4], r[1:0]})
			4'd0: s = 5'd7;
			4'd1: s = 5'd12;
			4'd2: s = 5'd17;
			4'd3: s = 5'd22;
			4'd4: s = 5'd5;
			4'd5: s = 5'd9;
			4'd6: s = 5'd14;
			4'd7: s = 5'd20;
			4'd8: s = 5'd4;
			4'd9: s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word schedule, all arithmetic mod 16
	function automatic logic [3:0] msg_index(input logic [5:0] r);
		logic [3:0] lo;
		logic [3:0] g;
		lo = r[3:0];
		case (r[5:4])
			2'd0: g = lo;
			2'd1: g = 4'((lo << 2) + lo + 4'd1);
			2'd2: g = 4'((lo << 1) + lo + 4'd5);
			default: g = 4'((lo << 3) - lo);
		endcase
		return g;
	endfunction

	function automatic word_t round_mix(input logic [1:0] grp, input word_t b, input word_t c,
			input word_t d);
		word_t f;
		case (grp)
			2'd0: f = (b & c) | (~b & d);
			2'd1: f = (d & b) | (~d & c);
			2'd2: f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic word_t rotl(input word_t v, input logic [4:0] s);
		logic [63:0] dbl;
		dbl = {v, v} << s;
		return dbl[63:32];
	endfunction

endpackage

// File: sv/md5_ifs.sv
// md5_ifs: valid/ready channel interfaces for message bytes and digest words
// no dependencies

interface md5_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface md5_out_if;
	logic valid;
	logic ready;
	logic [31:0] digest_word;
	logic [1:0] word_index;
	logic last;

	modport source (output valid, output digest_word, output word_index, output last,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last,
		output ready);
endinterface

// File: sv/md5_msg_buf.sv
// md5_msg_buf: 16-word block buffer with byte writes and padding applied on read
// depends on md5_pkg

module md5_msg_buf (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [5:0]      wr_addr,
	input  logic [7:0]      wr_data,
	input  logic [3:0]      rd_idx,
	input  md5_pkg::pad_t   pad,
	input  logic [5:0]      fill,
	input  logic [63:0]     bit_len,
	output md5_pkg::word_t  rd_word
);
	import md5_pkg::*;

	word_t msg_q [16];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			msg_q[wr_addr[5:2]][8*wr_addr[1:0] +: 8] <= wr_data;
		end
	end

	always_comb begin
		logic [5:0] pos;
		word_t w;
		w = msg_q[rd_idx];
		for (int k = 0; k < 4; k++) begin
			pos = {rd_idx, 2'(k)};
			if (pad.active) begin
				if (pad.mark && pos == fill) begin
					w[8*k +: 8] = PAD_BYTE;
				end else if (!pad.mark || pos > fill) begin
					w[8*k +: 8] = 8'h00;
				end
			end
		end
		if (pad.active && pad.len && rd_idx == LEN_WORD_LO) begin
			w = bit_len[31:0];
		end else if (pad.active && pad.len && rd_idx == LEN_WORD_HI) begin
			w = bit_len[63:32];
		end
		rd_word = w;
	end

endmodule

// File: sv/md5_round_unit.sv
// md5_round_unit: working registers a..d, round counter and the shared round datapath
// depends on md5_pkg; message words come from md5_msg_buf

module md5_round_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::rnd_ctrl_t ctrl,
	input  md5_pkg::quad_t    chain,
	input  md5_pkg::word_t    msg_word,
	output logic [3:0]        msg_idx,
	output logic              last_round,
	output md5_pkg::quad_t    work
);
	import md5_pkg::*;

	logic [5:0] rnd_q;
	logic [5:0] rnd_next;
	word_t a_q, b_q, c_q, d_q;
	word_t kw_q;
	word_t t_sum;
	word_t b_new;

	// index of the round whose constant and word are prefetched this cycle
	assign rnd_next = ctrl.load ? 6'd0 : 6'(rnd_q + 6'd1);
	assign msg_idx = msg_index(rnd_next);
	assign last_round = (rnd_q == LAST_ROUND);

	assign t_sum = round_mix(rnd_q[5:4], b_q, c_q, d_q) + a_q + kw_q;
	assign b_new = b_q + rotl(t_sum, rot_amount(rnd_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (ctrl.load || ctrl.step) begin
			rnd_q <= rnd_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain[0];
			b_q <= chain[1];
			c_q <= chain[2];
			d_q <= chain[3];
		end else if (ctrl.step) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
		if (ctrl.load || ctrl.step) begin
			kw_q <= round_const(rnd_next) + msg_word;
		end
	end

	assign work[0] = a_q;
	assign work[1] = b_q;
	assign work[2] = c_q;
	assign work[3] = d_q;

endmodule

// File: sv/md5_stream_hash.sv
// md5_stream_hash: top level, byte intake, padding sequencer, chaining words, digest output
// depends on md5_pkg, md5_ifs, md5_msg_buf, md5_round_unit
//
//   channel  dir  payload                          beat
//   msg      in   action, data_byte                one byte or one finish
//   digest   out  digest_word, word_index, last    one chaining word, four per finish
//
// the 64th byte of a block starts the block sequence: a prefetch state, 64 rounds
// through the single round unit, then a fold state
// a finish beat runs the same sequence on the padded block, or on two blocks when the length
// spills into a second block, then four digest beats; msg.ready is low throughout
// digest beats hold while digest.ready is low
// reset loads the initial chaining words and clears the fill index and byte count

module md5_stream_hash (
	input  logic       clk,
	input  logic       arst_n,
	md5_in_if.sink     msg,
	md5_out_if.source  digest
);
	import md5_pkg::*;

	state_t     state_q, state_next;
	quad_t      chain_q;
	quad_t      work;
	logic [5:0] fill_q;
	logic [60:0] count_q;
	pad_t       pad_q;
	logic       fin_q;
	logic [1:0] out_idx_q;
	rnd_ctrl_t  ctrl;
	logic [3:0] msg_idx;
	word_t      msg_word;
	logic       last_round;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = msg.valid && msg.ready;
	assign out_acc = digest.valid && digest.ready;

	md5_msg_buf u_buf (
		.clk     (clk),
		.wr_en   (in_acc && !msg.action),
		.wr_addr (fill_q),
		.wr_data (msg.data_byte),
		.rd_idx  (msg_idx),
		.pad     (pad_q),
		.fill    (fill_q),
		.bit_len ({count_q, 3'b000}),
		.rd_word (msg_word)
	);

	md5_round_unit u_round (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.chain      (chain_q),
		.msg_word   (msg_word),
		.msg_idx    (msg_idx),
		.last_round (last_round),
		.work       (work)
	);

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (msg.action || fill_q == LAST_BYTE)) begin
					state_next = ST_PREP;
				end
			end
			ST_PREP: state_next = ST_ROUND;
			ST_ROUND: begin
				if (last_round) begin
					state_next = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (fin_q && !pad_q.len) begin
					state_next = ST_PREP;
				end else if (fin_q) begin
					state_next = ST_EMIT;
				end else begin
					state_next = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_acc && out_idx_q == LAST_WORD) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		msg.ready = (state_q == ST_IDLE);
		digest.valid = (state_q == ST_EMIT);
		ctrl.load = (state_q == ST_PREP);
		ctrl.step = (state_q == ST_ROUND);
	end

	assign digest.digest_word = chain_q[out_idx_q];
	assign digest.word_index = out_idx_q;
	assign digest.last = (out_idx_q == LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			chain_q   <= {CHAIN_INIT3, CHAIN_INIT2, CHAIN_INIT1, CHAIN_INIT0};
			fill_q    <= '0;
			count_q   <= '0;
			pad_q     <= '0;
			fin_q     <= 1'b0;
			out_idx_q <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_IDLE: begin
					if (in_acc && !msg.action) begin
						fill_q  <= 6'(fill_q + 6'd1);
						count_q <= 61'(count_q + 61'd1);
					end else if (in_acc) begin
						fin_q        <= 1'b1;
						pad_q.active <= 1'b1;
						pad_q.mark   <= 1'b1;
						pad_q.len    <= (fill_q <= LEN_FIT_MAX);
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < 4; i++) begin
						chain_q[i] <= chain_q[i] + work[i];
					end
					// length did not fit: one more block of zeros and the length
					if (fin_q && !pad_q.len) begin
						pad_q.mark <= 1'b0;
						pad_q.len  <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						out_idx_q <= 2'(out_idx_q + 2'd1);
						if (out_idx_q == LAST_WORD) begin
							chain_q <= {CHAIN_INIT3, CHAIN_INIT2, CHAIN_INIT1, CHAIN_INIT0};
							fill_q  <= '0;
							count_q <= '0;
							pad_q   <= '0;
							fin_q   <= 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_round_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && last_round) |=> state_q == ST_FOLD)
		else $error("round sequence did not end in fold");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		msg.ready |-> !digest.valid)
		else $error("input ready while digest beats pending");

	a_digest_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && digest.last) |=> (msg.ready && fill_q == 6'd0 && count_q == 61'd0))
		else $error("state not cleared after last digest beat");

	a_pad_only_fin: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q.active |-> fin_q)
		else $error("padding active outside a finish");

endmodule
